[rtl/dprt_pkg.sv]
package dprt_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PAGES_W = 21;
  localparam int unsigned SRC_W   = 20;
  localparam int unsigned ST_W    = 3;

  localparam logic [1:0] ACT_DEF_CONTENT = 2'd0;
  localparam logic [1:0] ACT_DEF_ZERO    = 2'd1;
  localparam logic [1:0] ACT_ACTIVATE    = 2'd2;
  localparam logic [1:0] ACT_LIST        = 2'd3;

  localparam logic [ST_W-1:0] ST_NEW      = 3'd0;
  localparam logic [ST_W-1:0] ST_APPEND   = 3'd1;
  localparam logic [ST_W-1:0] ST_PREPEND  = 3'd2;
  localparam logic [ST_W-1:0] ST_PRESENT  = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;
  localparam logic [ST_W-1:0] ST_OK       = 3'd6;

  localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;         // capture input request
    logic clr_idx;      // index <= 0
    logic inc_idx;      // index <= index + 1
    logic sel_zero;     // work on zero kind
    logic define;       // write region at count
    logic rgn_step;     // test region entry at index
    logic rng_step;     // test range entry at index
    logic rng_new;      // append a new range
    logic list_rd;      // read range for listing
  } dprt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] action;
    logic       rgn_end;    // index reached region count
    logic       rgn_hit;
    logic       rng_end;    // index reached range count
    logic       rng_done;   // range test resolved
    logic       rng_full;
    logic       rgn_full;
    logic       list_empty;
    logic       list_last;  // range at index is the last one to list
  } dprt_sts_t;

endpackage

[rtl/dprt_datapath.sv]
module dprt_datapath
  import dprt_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT  = 12,
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned MAX_RANGES  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          action_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [PAGES_W-1:0]  page_count_i,
  input  dprt_cmd_t           cmd_i,
  output dprt_sts_t           sts_o,
  output logic [ST_W-1:0]     res_status_o,
  output logic                res_zero_o,
  output logic [ADDR_W-1:0]   res_start_o,
  output logic [PAGES_W-1:0]  res_pages_o,
  output logic [SRC_W-1:0]    res_source_o
);

  localparam int unsigned PG_W  = ADDR_W - PAGE_SHIFT;
  localparam int unsigned E_W   = ((PG_W > PAGES_W) ? PG_W : PAGES_W) + 1;
  localparam int unsigned RGI_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned RNI_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned RGC_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned RNC_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned IDX_W = (RGC_W > RNC_W) ? RGC_W : RNC_W;

  logic [PG_W-1:0]    crg_start [MAX_REGIONS];
  logic [PAGES_W-1:0] crg_pages [MAX_REGIONS];
  logic [SRC_W-1:0]   crg_base  [MAX_REGIONS];
  logic [PG_W-1:0]    zrg_start [MAX_REGIONS];
  logic [PAGES_W-1:0] zrg_pages [MAX_REGIONS];
  logic [PG_W-1:0]    crn_start [MAX_RANGES];
  logic [PAGES_W-1:0] crn_pages [MAX_RANGES];
  logic [SRC_W-1:0]   crn_src   [MAX_RANGES];
  logic [PG_W-1:0]    zrn_start [MAX_RANGES];
  logic [PAGES_W-1:0] zrn_pages [MAX_RANGES];

  logic [RGC_W-1:0]   crg_cnt_q, zrg_cnt_q;
  logic [RNC_W-1:0]   crn_cnt_q, zrn_cnt_q;
  logic [PAGES_W-1:0] backing_q;

  logic [1:0]         act_q;
  logic [PG_W-1:0]    pg_q;
  logic [PAGES_W-1:0] cnt_q;
  logic [IDX_W-1:0]   idx_q;
  logic               first_q, last_q;
  logic [SRC_W-1:0]   src_q;

  logic [RGI_W-1:0] rgi;
  logic [RNI_W-1:0] rni;
  assign rgi = idx_q[RGI_W-1:0];
  assign rni = idx_q[RNI_W-1:0];

  // Region test at idx.
  logic [PG_W-1:0]    rg_s;
  logic [PAGES_W-1:0] rg_p;
  logic [E_W-1:0]     rg_e;
  logic               rg_hit;
  logic [RGC_W-1:0]   rg_cnt;
  always_comb begin
    rg_s   = cmd_i.sel_zero ? zrg_start[rgi] : crg_start[rgi];
    rg_p   = cmd_i.sel_zero ? zrg_pages[rgi] : crg_pages[rgi];
    rg_e   = E_W'(rg_s) + E_W'(rg_p);
    rg_hit = (pg_q >= rg_s) && (E_W'(pg_q) < rg_e);
    rg_cnt = cmd_i.sel_zero ? zrg_cnt_q : crg_cnt_q;
  end

  // Range test at idx.
  logic [PG_W-1:0]    rn_s;
  logic [PAGES_W-1:0] rn_p;
  logic [E_W-1:0]     rn_e;
  logic               rn_in, rn_app, rn_pre;
  logic [RNC_W-1:0]   rn_cnt;
  logic [PAGES_W-1:0] rn_grow;
  always_comb begin
    rn_s    = cmd_i.sel_zero ? zrn_start[rni] : crn_start[rni];
    rn_p    = cmd_i.sel_zero ? zrn_pages[rni] : crn_pages[rni];
    rn_e    = E_W'(rn_s) + E_W'(rn_p);
    rn_in   = (pg_q >= rn_s) && (E_W'(pg_q) < rn_e);
    rn_app  = !first_q && (rn_e == E_W'(pg_q));
    rn_pre  = !last_q && (({1'b0, pg_q} + 1'b1) == {1'b0, rn_s});
    rn_cnt  = cmd_i.sel_zero ? zrn_cnt_q : crn_cnt_q;
    rn_grow = (rn_p == PAGES_MAX) ? PAGES_MAX : rn_p + 1'b1;
  end

  assign sts_o.action     = act_q;
  assign sts_o.rgn_end    = (IDX_W'(rg_cnt) <= idx_q);
  assign sts_o.rgn_hit    = rg_hit;
  assign sts_o.rng_end    = (IDX_W'(rn_cnt) <= idx_q);
  assign sts_o.rng_done   = rn_in || rn_app || rn_pre;
  assign sts_o.rng_full   = (rn_cnt >= RNC_W'(MAX_RANGES));
  assign sts_o.rgn_full   = (act_q == ACT_DEF_ZERO) ? (zrg_cnt_q >= RGC_W'(MAX_REGIONS))
                                                    : (crg_cnt_q >= RGC_W'(MAX_REGIONS));
  assign sts_o.list_empty = (crn_cnt_q == '0) && (zrn_cnt_q == '0);
  // No later entry in this kind, and no zero ranges follow a content one.
  assign sts_o.list_last  = (IDX_W'(rn_cnt) <= (idx_q + 1'b1)) &&
                            (cmd_i.sel_zero || (zrn_cnt_q == '0));

  logic [RGI_W-1:0] rgw;
  logic [RNI_W-1:0] rnw;
  assign rgw = (act_q == ACT_DEF_ZERO) ? zrg_cnt_q[RGI_W-1:0] : crg_cnt_q[RGI_W-1:0];
  assign rnw = rn_cnt[RNI_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crg_cnt_q <= '0;
      zrg_cnt_q <= '0;
      crn_cnt_q <= '0;
      zrn_cnt_q <= '0;
      backing_q <= '0;
      idx_q     <= '0;
      act_q     <= ACT_DEF_CONTENT;
    end else begin
      if (cmd_i.load) act_q <= action_i;
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.inc_idx) idx_q <= idx_q + 1'b1;
      if (cmd_i.define) begin
        if (act_q == ACT_DEF_ZERO) zrg_cnt_q <= zrg_cnt_q + 1'b1;
        else begin
          crg_cnt_q <= crg_cnt_q + 1'b1;
          backing_q <= backing_q + cnt_q;
        end
      end
      if (cmd_i.rng_new) begin
        if (cmd_i.sel_zero) zrn_cnt_q <= zrn_cnt_q + 1'b1;
        else crn_cnt_q <= crn_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pg_q  <= address_i[ADDR_W-1:PAGE_SHIFT];
      cnt_q <= page_count_i;
    end
    if (cmd_i.define) begin
      if (act_q == ACT_DEF_ZERO) begin
        zrg_start[rgw] <= pg_q;
        zrg_pages[rgw] <= cnt_q;
      end else begin
        crg_start[rgw] <= pg_q;
        crg_pages[rgw] <= cnt_q;
        crg_base[rgw]  <= backing_q[SRC_W-1:0];
      end
    end
    if (cmd_i.rgn_step && rg_hit) begin
      first_q <= (pg_q == rg_s);
      last_q  <= ((E_W'(pg_q) + 1'b1) == rg_e);
      src_q   <= crg_base[rgi] + SRC_W'(pg_q - rg_s);
    end
    if (cmd_i.rng_step && !rn_in) begin
      if (rn_app) begin
        if (cmd_i.sel_zero) zrn_pages[rni] <= rn_grow;
        else crn_pages[rni] <= rn_grow;
      end else if (rn_pre) begin
        if (cmd_i.sel_zero) begin
          zrn_start[rni] <= rn_s - 1'b1;
          zrn_pages[rni] <= rn_grow;
        end else begin
          crn_start[rni] <= rn_s - 1'b1;
          crn_pages[rni] <= rn_grow;
          crn_src[rni]   <= crn_src[rni] - 1'b1;
        end
      end
    end
    if (cmd_i.rng_new) begin
      if (cmd_i.sel_zero) begin
        zrn_start[rnw] <= pg_q;
        zrn_pages[rnw] <= PAGES_W'(1);
      end else begin
        crn_start[rnw] <= pg_q;
        crn_pages[rnw] <= PAGES_W'(1);
        crn_src[rnw]   <= src_q;
      end
    end
  end

  // Result fields; res_status_o is used only for a resolved range test, the controller supplies every other status.
  always_comb begin
    res_status_o = ST_OK;
    if (rn_in) res_status_o = ST_PRESENT;
    else if (rn_app) res_status_o = ST_APPEND;
    else if (rn_pre) res_status_o = ST_PREPEND;
    res_zero_o   = cmd_i.sel_zero;
    res_start_o  = {rn_s, {PAGE_SHIFT{1'b0}}};
    res_pages_o  = rn_p;
    res_source_o = cmd_i.sel_zero ? '0 : crn_src[rni];
  end

endmodule

[rtl/dprt_ctrl.sv]
module dprt_ctrl
  import dprt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  dprt_sts_t          sts_i,
  input  logic [ST_W-1:0]    res_status_i,
  input  logic               res_zero_i,
  input  logic [ADDR_W-1:0]  res_start_i,
  input  logic [PAGES_W-1:0] res_pages_i,
  input  logic [SRC_W-1:0]   res_source_i,
  output dprt_cmd_t          cmd_o,
  output logic [ST_W-1:0]    status_o,
  output logic               range_is_zero_o,
  output logic [ADDR_W-1:0]  range_start_o,
  output logic [PAGES_W-1:0] range_pages_o,
  output logic [SRC_W-1:0]   source_page_o,
  output logic               last_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RGN  = 7'b0000100,
    S_RNG  = 7'b0001000,
    S_LIST = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_LOUT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   zero_q, zero_d;
  logic   ov_q;
  logic   ld_res, ld_last;
  logic [ST_W-1:0] st_sel;
  logic [5:0] nout_q;

  // Last listed result: no more ranges after this one, or 32 emitted.
  logic list_last;
  assign list_last = sts_i.list_last;

  always_comb begin
    state_d = state_q;
    zero_d  = zero_q;
    cmd_o   = '0;
    cmd_o.sel_zero = zero_q;
    ld_res  = 1'b0;
    ld_last = 1'b1;
    st_sel  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_idx = 1'b1;
          zero_d        = 1'b0;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.action)
          ACT_DEF_CONTENT, ACT_DEF_ZERO: begin
            ld_res = 1'b1;
            st_sel = sts_i.rgn_full ? ST_FULL : ST_OK;
            cmd_o.define = !sts_i.rgn_full;
            state_d = S_OUT;
          end
          ACT_ACTIVATE: state_d = S_RGN;
          default: begin
            if (sts_i.list_empty) begin
              ld_res = 1'b1;
              state_d = S_OUT;
            end else begin
              state_d = S_LIST;
            end
          end
        endcase
      end
      S_RGN: begin
        cmd_o.rgn_step = 1'b1;
        if (sts_i.rgn_end) begin
          cmd_o.clr_idx = 1'b1;
          if (zero_q) begin
            ld_res = 1'b1;
            st_sel = ST_NOTFOUND;
            state_d = S_OUT;
          end else begin
            zero_d = 1'b1;
          end
        end else if (sts_i.rgn_hit) begin
          cmd_o.clr_idx = 1'b1;
          state_d = S_RNG;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_RNG: begin
        if (sts_i.rng_end) begin
          ld_res = 1'b1;
          st_sel = sts_i.rng_full ? ST_FULL : ST_NEW;
          cmd_o.rng_new = !sts_i.rng_full;
          state_d = S_OUT;
        end else begin
          cmd_o.rng_step = 1'b1;
          if (sts_i.rng_done) begin
            ld_res = 1'b1;
            st_sel = res_status_i;
            state_d = S_OUT;
          end else begin
            cmd_o.inc_idx = 1'b1;
          end
        end
      end
      S_LIST: begin
        if (sts_i.rng_end) begin
          cmd_o.clr_idx = 1'b1;
          zero_d = 1'b1;
          if (zero_q) begin
            // safety close out; the last listed range normally returns to idle from S_LOUT
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.list_rd = 1'b1;
          ld_res = 1'b1;
          ld_last = 1'b0;
          state_d = S_LOUT;
        end
      end
      S_LOUT: begin
        if (!out_stall_i) begin
          if (last_o) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.inc_idx = 1'b1;
            state_d = S_LIST;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;

  // Lookahead for last in list: the current entry is last when no later
  // entry exists in this kind and the zero table (if content) is empty, or when nout_d reaches 32.
  logic [5:0] nout_d;
  assign nout_d = nout_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      zero_q  <= 1'b0;
      ov_q    <= 1'b0;
      nout_q  <= '0;
    end else begin
      state_q <= state_d;
      zero_q  <= zero_d;
      if (ld_res) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      if (state_q == S_IDLE) nout_q <= '0;
      else if (ld_res && !ld_last) nout_q <= nout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_res) begin
      status_o        <= st_sel;
      range_is_zero_o <= ld_last ? 1'b0 : res_zero_i;
      range_start_o   <= ld_last ? '0 : res_start_i;
      range_pages_o   <= ld_last ? '0 : res_pages_i;
      source_page_o   <= ld_last ? '0 : res_source_i;
      last_o          <= ld_last | list_last | (nout_d == 6'd32);
    end
  end

endmodule

[rtl/dirty_page_range_tracker.sv]
// Dirty page range tracker.
// Input channel (in_valid_i / in_stall_o) carries one request: action,
// address, page_count. Output channel (out_valid_o / out_stall_i) returns
// results: status, range fields and last. Define and activate requests give
// one result; list gives one result per stored range (content ranges then
// zero ranges, at most 32), or one empty result, last set on the final one.
// Timing: one request at a time. Define decodes the request and registers
// its result. Activate walks the region tables and then one range table,
// one entry per cycle. List reads one range, registers it as a result and
// waits until it is taken before it reads the next.
// Reset clears all counts; table contents are undefined until written.
// When out_stall_i is high the result register holds and the block waits;
// no new request is taken until every result of the current one is taken.
module dirty_page_range_tracker
  import dprt_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT  = 12,
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned MAX_RANGES  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [20:0]        page_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ST_W-1:0]    status_o,
  output logic               range_is_zero_o,
  output logic [ADDR_W-1:0]  range_start_o,
  output logic [PAGES_W-1:0] range_pages_o,
  output logic [SRC_W-1:0]   source_page_o,
  output logic               last_o
);

  dprt_cmd_t cmd;
  dprt_sts_t sts;
  logic [ST_W-1:0]    r_status;
  logic               r_zero;
  logic [ADDR_W-1:0]  r_start;
  logic [PAGES_W-1:0] r_pages;
  logic [SRC_W-1:0]   r_source;

  dprt_datapath #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAX_REGIONS(MAX_REGIONS),
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk_i, .rst_ni, .action_i, .address_i, .page_count_i,
    .cmd_i(cmd), .sts_o(sts),
    .res_status_o(r_status), .res_zero_o(r_zero), .res_start_o(r_start),
    .res_pages_o(r_pages), .res_source_o(r_source)
  );

  dprt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .res_status_i(r_status), .res_zero_i(r_zero),
    .res_start_i(r_start), .res_pages_i(r_pages), .res_source_i(r_source),
    .cmd_o(cmd), .status_o, .range_is_zero_o, .range_start_o,
    .range_pages_o, .source_page_o, .last_o
  );

endmodule

[sim/tb_dirty_page_range_tracker.sv]
`timescale 1ns / 1ps

module tb_dirty_page_range_tracker;
  import dprt_pkg::*;

  localparam int unsigned PSHIFT   = 12;
  localparam int unsigned NREGIONS = 16;
  localparam int unsigned NRANGES  = 16;
  localparam int unsigned LIST_MAX = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  // One result as the block reports it.
  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic               is_zero;
    logic [ADDR_W-1:0]  start;
    logic [PAGES_W-1:0] pages;
    logic [SRC_W-1:0]   src;
    logic               fin;
  } range_reply_t;

  // Mirror of the region and restore-range tables; kind 0 is content,
  // kind 1 is zero fill.
  class restore_range_tracker;
    logic [SRC_W-1:0]   rgn_start[2][NREGIONS];
    logic [PAGES_W-1:0] rgn_pages[2][NREGIONS];
    logic [SRC_W-1:0]   rgn_base[NREGIONS];
    int unsigned        rgn_cnt[2];
    logic [PAGES_W-1:0] backing_next;
    logic [SRC_W-1:0]   rng_start[2][NRANGES];
    logic [PAGES_W-1:0] rng_pages[2][NRANGES];
    logic [SRC_W-1:0]   rng_src[NRANGES];
    int unsigned        rng_cnt[2];
    range_reply_t       pending_replies[$];
    int unsigned        errors;

    function new();
      rgn_cnt = '{0, 0};
      rng_cnt = '{0, 0};
      backing_next = '0;
      errors = 0;
    endfunction

    function logic [PAGES_W-1:0] grow(logic [PAGES_W-1:0] p);
      return (p == PAGES_MAX) ? p : p + 1'b1;
    endfunction

    // Fold page pg into the range table of one kind.
    function logic [ST_W-1:0] merge_page(int k, logic [SRC_W-1:0] pg, bit first_pg,
                                         bit last_pg, logic [SRC_W-1:0] src);
      logic [21:0] rs, re;
      for (int j = 0; j < rng_cnt[k]; j++) begin
        rs = rng_start[k][j];
        re = rs + rng_pages[k][j];
        if (pg >= rs && pg < re) return ST_PRESENT;
        if (!first_pg && re == {2'b0, pg}) begin
          rng_pages[k][j] = grow(rng_pages[k][j]);
          return ST_APPEND;
        end
        if (!last_pg && ({2'b0, pg} + 22'd1) == rs) begin
          rng_start[k][j] = rng_start[k][j] - 1'b1;
          if (k == 0) rng_src[j] = rng_src[j] - 1'b1;
          rng_pages[k][j] = grow(rng_pages[k][j]);
          return ST_PREPEND;
        end
      end
      if (rng_cnt[k] >= NRANGES) return ST_FULL;
      rng_start[k][rng_cnt[k]] = pg;
      rng_pages[k][rng_cnt[k]] = 1;
      if (k == 0) rng_src[rng_cnt[k]] = src;
      rng_cnt[k]++;
      return ST_NEW;
    endfunction

    function logic [ST_W-1:0] activate_page(logic [ADDR_W-1:0] addr);
      logic [SRC_W-1:0] pg;
      logic [21:0] s, e;
      pg = addr[ADDR_W-1:PSHIFT];
      // content regions win over zero regions
      for (int k = 0; k < 2; k++)
        for (int i = 0; i < rgn_cnt[k]; i++) begin
          s = rgn_start[k][i];
          e = s + rgn_pages[k][i];
          if (pg >= s && pg < e)
            return merge_page(k, pg, pg == s, ({2'b0, pg} + 22'd1) == e,
                              (k == 0) ? rgn_base[i] + (pg - s[SRC_W-1:0]) : '0);
        end
      return ST_NOTFOUND;
    endfunction

    function void note_request(logic [1:0] act, logic [ADDR_W-1:0] addr,
                               logic [20:0] cnt);
      range_reply_t r;
      int k;
      int n;
      r = '0;
      r.fin = 1'b1;
      case (act)
        ACT_DEF_CONTENT, ACT_DEF_ZERO: begin
          k = (act == ACT_DEF_ZERO);
          if (rgn_cnt[k] >= NREGIONS) begin
            r.status = ST_FULL;
          end else begin
            rgn_start[k][rgn_cnt[k]] = addr[ADDR_W-1:PSHIFT];
            rgn_pages[k][rgn_cnt[k]] = cnt;
            if (k == 0) begin
              rgn_base[rgn_cnt[k]] = backing_next[SRC_W-1:0];
              backing_next = backing_next + cnt;
            end
            rgn_cnt[k]++;
            r.status = ST_OK;
          end
          pending_replies.push_back(r);
        end
        ACT_ACTIVATE: begin
          r.status = activate_page(addr);
          pending_replies.push_back(r);
        end
        default: begin
          n = 0;
          for (k = 0; k < 2; k++)
            for (int i = 0; i < rng_cnt[k] && n < LIST_MAX; i++) begin
              r.status  = ST_OK;
              r.is_zero = (k == 1);
              r.start   = {rng_start[k][i], {PSHIFT{1'b0}}};
              r.pages   = rng_pages[k][i];
              r.src     = (k == 0) ? rng_src[i] : '0;
              r.fin     = 1'b0;
              pending_replies.push_back(r);
              n++;
            end
          if (n == 0) begin
            r = '0;
            r.status = ST_OK;
            pending_replies.push_back(r);
          end
          pending_replies[pending_replies.size()-1].fin = 1'b1;
        end
      endcase
    endfunction

    function void check_result(range_reply_t got);
      range_reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.is_zero !== want.is_zero) begin
        $display("%0t: range_is_zero exp %0d got %0d", $time, want.is_zero, got.is_zero);
        errors++;
      end
      if (got.start !== want.start) begin
        $display("%0t: range_start exp %h got %h", $time, want.start, got.start);
        errors++;
      end
      if (got.pages !== want.pages) begin
        $display("%0t: range_pages exp %h got %h", $time, want.pages, got.pages);
        errors++;
      end
      if (got.src !== want.src) begin
        $display("%0t: source_page exp %h got %h", $time, want.src, got.src);
        errors++;
      end
      if (got.fin !== want.fin) begin
        $display("%0t: last exp %0d got %0d", $time, want.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         action_i;
  logic [ADDR_W-1:0]  address_i;
  logic [20:0]        page_count_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ST_W-1:0]    status_o;
  logic               range_is_zero_o;
  logic [ADDR_W-1:0]  range_start_o;
  logic [PAGES_W-1:0] range_pages_o;
  logic [SRC_W-1:0]   source_page_o;
  logic               last_o;

  restore_range_tracker tracker = new();
  int unsigned cycles;
  int unsigned sent;          // requests accepted so far
  bit          no_idle;       // stretch where neither side idles
  bit          holdoff_done;

  dirty_page_range_tracker #(
    .PAGE_SHIFT (PSHIFT),
    .MAX_REGIONS(NREGIONS),
    .MAX_RANGES (NRANGES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .address_i      (address_i),
    .page_count_i   (page_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .range_is_zero_o(range_is_zero_o),
    .range_start_o  (range_start_o),
    .range_pages_o  (range_pages_o),
    .source_page_o  (source_page_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: no correct run comes near this.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: check every accepted result, stall at random, and once
  // hold off for a long stretch so the block backs up into its input.
  initial begin
    int unsigned hold;
    hold = 0;
    holdoff_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        tracker.check_result({status_o, range_is_zero_o, range_start_o,
                              range_pages_o, source_page_o, last_o});
      if (!holdoff_done && sent >= 120) begin
        holdoff_done = 1'b1;
        hold = HOLDOFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 32);
      end
    end
  end

  // Offer one request; valid stays high into the next call.
  task automatic send_request(logic [1:0] act, logic [ADDR_W-1:0] addr, logic [20:0] cnt);
    if (!no_idle && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    address_i    <= addr;
    page_count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(act, addr, cnt);
    sent++;
  endtask

  // Pages near the defined regions, so most requests land in or next to one.
  function automatic logic [ADDR_W-1:0] near_addr();
    return {12'h000, 8'($urandom_range(8'hA3, 8'h3C)), 12'($urandom)};
  endfunction

  initial begin
    int unsigned pick;
    logic [20:0] cnt;
    sent = 0;
    no_idle = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_LIST;
    address_i = '0;
    page_count_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, miss, merge cases, zero-length region,
    // regions at the top of the address space, backing store wrap.
    send_request(ACT_LIST,        32'h0000_0000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0000_1234, 21'd0);
    send_request(ACT_DEF_CONTENT, 32'h0004_0000, 21'd4);
    send_request(ACT_DEF_CONTENT, 32'h0005_0000, 21'd0);
    send_request(ACT_DEF_ZERO,    32'h0004_8000, 21'd4);
    send_request(ACT_ACTIVATE,    32'h0004_1abc, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0004_2000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0004_0fff, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0004_3000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0004_1000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0005_0000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0004_9000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0004_A000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0004_8000, 21'd0);
    send_request(ACT_DEF_CONTENT, 32'hFFFF_F000, 21'd1048576);
    send_request(ACT_DEF_CONTENT, 32'hFFFF_EFFF, 21'd1048576);
    send_request(ACT_DEF_CONTENT, 32'h0006_0000, 21'd2);
    send_request(ACT_ACTIVATE,    32'hFFFF_FFFF, 21'd0);
    send_request(ACT_ACTIVATE,    32'hFFFF_E000, 21'd0);
    send_request(ACT_ACTIVATE,    32'h0006_1000, 21'd0);
    send_request(ACT_LIST,        32'hFFFF_FFFF, 21'h1FFFFF);

    // Random: mostly activations near the regions, defines until the
    // tables fill, some lists and some requests anywhere.
    for (int n = 0; n < 260; n++) begin
      no_idle = (n >= 180 && n < 220);
      pick = $urandom_range(99);
      cnt = ($urandom_range(19) == 0) ? 21'($urandom_range(1048576))
                                      : 21'($urandom_range(8));
      if (pick < 10)
        send_request(ACT_DEF_CONTENT, near_addr(), cnt);
      else if (pick < 18)
        send_request(ACT_DEF_ZERO, near_addr(), cnt);
      else if (pick < 85)
        send_request(ACT_ACTIVATE, near_addr(), 21'($urandom));
      else if (pick < 91)
        send_request(ACT_LIST, $urandom, 21'($urandom));
      else
        send_request(2'($urandom), $urandom, 21'($urandom));
    end
    in_valid_i <= 1'b0;

    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
rtl/dprt_pkg.sv
rtl/dprt_datapath.sv
rtl/dprt_ctrl.sv
rtl/dirty_page_range_tracker.sv
sim/tb_dirty_page_range_tracker.sv
